>>> rtl/core/rir_pkg.sv
// Shared types and constants of the frame rotation engine.
package rir_pkg;

	localparam int MAX_SIDE   = 256;
	localparam int CNT_W      = $clog2(MAX_SIDE);
	localparam int SIDE_W     = CNT_W + 1;
	localparam int DEPTH      = MAX_SIDE * MAX_SIDE;
	localparam int ADDR_W     = $clog2(DEPTH);
	localparam int PIX_W      = 8;
	localparam int CFG_W      = 9;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

	localparam int RESET_SIDE = (256 > MAX_SIDE) ? MAX_SIDE : 256;
	localparam logic [CNT_W-1:0]  RESET_SIDE_M1 = CNT_W'(RESET_SIDE - 1);
	localparam logic [ADDR_W-1:0] RESET_BASE    = ADDR_W'((RESET_SIDE - 1) * RESET_SIDE);

	typedef struct packed {
		logic             kind;
		logic [PIX_W-1:0] pixel_in;
	} req_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_out;
		logic             frame_last;
	} rsp_t;

	typedef struct packed {
		logic                 we;
		logic [CFG_IDX_W-1:0] index;
		logic [CFG_W-1:0]     data;
	} cfg_wr_t;

	typedef struct packed {
		logic              we;
		logic              re;
		logic [ADDR_W-1:0] addr;
		logic [PIX_W-1:0]  wdata;
		logic              last;
	} ram_cmd_t;

	// Side length minus one, with zero taken as one and oversize clamped.
	function automatic logic [CNT_W-1:0] side_m1(input logic [CFG_W-1:0] v);
		logic [CNT_W-1:0] r;
		if (v == '0)
			r = '0;
		else if (int'(v) > MAX_SIDE)
			r = CNT_W'(MAX_SIDE - 1);
		else
			r = CNT_W'(int'(v) - 1);
		return r;
	endfunction

endpackage

>>> rtl/core/rir_ram.sv
// Generic single-port RAM with registered read.
module rir_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		if (re)
			rdata <= mem[addr];
	end

endmodule

>>> rtl/core/rir_addr_gen.sv
// Frame geometry registers and the load and rotated-read address counters.
module rir_addr_gen (
	input  logic                clk,
	input  logic                arst_n,
	input  rir_pkg::cfg_wr_t    cfg,
	input  logic                load_acc,
	input  logic                read_acc,
	input  logic [rir_pkg::PIX_W-1:0] pixel_in,
	output logic                settle,
	output rir_pkg::ram_cmd_t   cmd
);

	logic [rir_pkg::CNT_W-1:0]  wm1_q, hm1_q;
	logic [rir_pkg::ADDR_W-1:0] base_q;
	logic                       settle_q;
	logic [rir_pkg::CNT_W-1:0]  ld_col_q, ld_row_q;
	logic [rir_pkg::ADDR_W-1:0] ld_addr_q;
	logic [rir_pkg::CNT_W-1:0]  rd_col_q, rd_row_q;
	logic [rir_pkg::ADDR_W-1:0] rd_addr_q;
	logic [rir_pkg::ADDR_W-1:0] rd_addr;
	logic [rir_pkg::SIDE_W-1:0] w_eff;
	logic                       rd_last;

	assign w_eff = rir_pkg::SIDE_W'(wm1_q) + rir_pkg::SIDE_W'(1);

	// Column zero of a rotated row starts in the bottom source row.
	assign rd_addr = (rd_col_q == '0) ? base_q + rir_pkg::ADDR_W'(rd_row_q)
	                                  : rd_addr_q - rir_pkg::ADDR_W'(w_eff);
	assign rd_last = (rd_row_q == wm1_q) && (rd_col_q == hm1_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wm1_q    <= rir_pkg::RESET_SIDE_M1;
			hm1_q    <= rir_pkg::RESET_SIDE_M1;
			base_q   <= rir_pkg::RESET_BASE;
			settle_q <= 1'b0;
		end else begin
			settle_q <= cfg.we;
			base_q   <= rir_pkg::ADDR_W'(hm1_q) * rir_pkg::ADDR_W'(w_eff);
			if (cfg.we) begin
				unique case (cfg.index)
					rir_pkg::REG_IMAGE_WIDTH:  wm1_q <= rir_pkg::side_m1(cfg.data);
					rir_pkg::REG_IMAGE_HEIGHT: hm1_q <= rir_pkg::side_m1(cfg.data);
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_col_q  <= '0;
			ld_row_q  <= '0;
			ld_addr_q <= '0;
			rd_col_q  <= '0;
			rd_row_q  <= '0;
			rd_addr_q <= '0;
		end else if (cfg.we && (cfg.index == rir_pkg::REG_IMAGE_WIDTH ||
		                        cfg.index == rir_pkg::REG_IMAGE_HEIGHT)) begin
			ld_col_q  <= '0;
			ld_row_q  <= '0;
			ld_addr_q <= '0;
			rd_col_q  <= '0;
			rd_row_q  <= '0;
		end else begin
			if (load_acc) begin
				if (ld_col_q == wm1_q) begin
					ld_col_q <= '0;
					if (ld_row_q == hm1_q) begin
						ld_row_q  <= '0;
						ld_addr_q <= '0;
					end else begin
						ld_row_q  <= ld_row_q + rir_pkg::CNT_W'(1);
						ld_addr_q <= ld_addr_q + rir_pkg::ADDR_W'(1);
					end
				end else begin
					ld_col_q  <= ld_col_q + rir_pkg::CNT_W'(1);
					ld_addr_q <= ld_addr_q + rir_pkg::ADDR_W'(1);
				end
			end
			if (read_acc) begin
				rd_addr_q <= rd_addr;
				if (rd_col_q == hm1_q) begin
					rd_col_q <= '0;
					rd_row_q <= (rd_row_q == wm1_q) ? '0 : rd_row_q + rir_pkg::CNT_W'(1);
				end else begin
					rd_col_q <= rd_col_q + rir_pkg::CNT_W'(1);
				end
			end
		end
	end

	assign settle = settle_q;

	always_comb begin
		cmd.we    = load_acc;
		cmd.re    = read_acc;
		cmd.addr  = load_acc ? ld_addr_q : rd_addr;
		cmd.wdata = pixel_in;
		cmd.last  = rd_last;
	end

endmodule

>>> rtl/core/rotate_image_90_clockwise.sv
// A read request's pixel is registered and presented in the cycle after acceptance; loads give nothing.
// Throughput: one request per cycle unless a register write settles or a held result stalls a read,
// set by the single port of the pixel store, which takes one load write or one rotated read each cycle.
// A register write holds off requests in the cycle after it while the row base product settles.
// Reset clears the counters and sets both sides to 256; the pixel store is not cleared
// and holds nothing defined until loaded.
module rotate_image_90_clockwise (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rir_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rir_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  rir_pkg::req_t                 req,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output rir_pkg::rsp_t                 rsp
);

	rir_pkg::cfg_wr_t  cfg;
	rir_pkg::ram_cmd_t cmd;
	logic              settle;
	logic              load_acc, read_acc;
	logic              rsp_valid_q;
	logic              last_q;
	logic [rir_pkg::PIX_W-1:0] rdata;

	assign cfg = '{we: cfg_we, index: cfg_index, data: cfg_data};

	// A read may enter when the held result leaves in the same cycle.
	assign req_ready = !settle && (!req.kind || !rsp_valid_q || rsp_ready);
	assign load_acc  = req_valid && req_ready && !req.kind;
	assign read_acc  = req_valid && req_ready && req.kind;

	rir_addr_gen u_addr (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.load_acc (load_acc),
		.read_acc (read_acc),
		.pixel_in (req.pixel_in),
		.settle   (settle),
		.cmd      (cmd)
	);

	rir_ram #(
		.WIDTH (rir_pkg::PIX_W),
		.DEPTH (rir_pkg::DEPTH)
	) u_store (
		.clk   (clk),
		.we    (cmd.we),
		.re    (cmd.re),
		.addr  (cmd.addr),
		.wdata (cmd.wdata),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (read_acc) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (read_acc)
			last_q <= cmd.last;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = '{pixel_out: rdata, frame_last: last_q};

	a_read_gives_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		read_acc |=> rsp_valid)
		else $error("read request did not produce a result");

	a_load_no_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(load_acc && !rsp_valid) |=> !rsp_valid)
		else $error("load request produced a result");

	a_cfg_holds_off: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !req_ready)
		else $error("request taken while geometry settles");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |-> !read_acc)
		else $error("read accepted over a held result");

endmodule
